// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// All checks sample on the rising clock edge and are off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on clk_i, off during reset.
`define RDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define RDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rde_pkg.sv -----
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants and codes for the reversible deque engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

  // Store geometry; DEPTH must be a power of two so pointers wrap naturally
  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH) + 1;

  // Command codes
  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_REVERSE = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_TAKE    = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ----- sv/reversible_deque_engine.sv -----
// ----------------------------------------------------------------------------
// reversible_deque_engine
// Ring-buffer deque with a direction bit, held in one synchronous memory.
// ----------------------------------------------------------------------------
// The engine takes one command per cycle and returns exactly one result beat
// per command. Pointers, count and flags live in registers; elements live in
// a 1024 x 16 single-port-read, single-port-write memory with a registered
// read. Every command's result is registered and shows up the cycle after
// the command is accepted; a take-out reads the memory at acceptance and the
// registered read data forms the returned word in that same following cycle.
// A one-beat output register separates the sides: a new command is taken
// whenever that register is empty or being drained in the same cycle, so with
// the sink always ready the sustained rate is one command per clock. No
// clearing pass is needed after reset; only live entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module reversible_deque_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Command channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [15:0] data_word_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      out_word_o,
  output logic             last_one_o
);

  localparam int unsigned PtrW  = rde_pkg::PTR_W;
  localparam int unsigned CntW  = rde_pkg::CNT_W;
  localparam int unsigned WordW = rde_pkg::WORD_BITS;

  // Control state
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic            rev_q, rev_d;
  logic            err_q, err_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  rde_pkg::status_e status_q, status_d;
  logic             last_q, last_d;
  logic             word_sel_q, word_sel_d;

  // Element store
  logic [WordW-1:0] mem [rde_pkg::DEPTH];
  logic [WordW-1:0] rd_data_q;
  logic             mem_we;
  logic [PtrW-1:0]  mem_waddr;
  logic             mem_re;
  logic [PtrW-1:0]  mem_raddr;

  logic            in_fire;
  logic            is_empty;
  logic            is_full;
  logic [PtrW-1:0] tail_slot;
  logic [PtrW-1:0] head_dec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CntW'(rde_pkg::DEPTH));
  // Physical slot one past the last element in normal order
  assign tail_slot  = head_q + count_q[PtrW-1:0];
  assign head_dec   = head_q - PtrW'(1);

  // Decode the command and compute the next state and result
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    rev_d       = rev_q;
    err_d       = err_q;
    status_d    = status_q;
    last_d      = last_q;
    word_sel_d  = word_sel_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_slot;
    mem_re      = 1'b0;
    mem_raddr   = head_q;

    // Drop the beat once the sink takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      out_valid_d = 1'b1;
      status_d    = rde_pkg::ST_OK;
      last_d      = 1'b0;
      word_sel_d  = 1'b0;
      if (cmd_i == rde_pkg::CMD_CLEAR) begin
        head_d  = '0;
        count_d = '0;
        rev_d   = 1'b0;
        err_d   = 1'b0;
      end else if (err_q) begin
        status_d = rde_pkg::ST_ERR;
      end else begin
        unique case (rde_pkg::cmd_e'(cmd_i))
          rde_pkg::CMD_LOAD: begin
            if (is_full) begin
              status_d = rde_pkg::ST_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CntW'(1);
              if (rev_q) begin
                head_d    = head_dec;
                mem_waddr = head_dec;
              end else begin
                mem_waddr = tail_slot;
              end
            end
          end
          rde_pkg::CMD_REVERSE: begin
            rev_d = !rev_q;
          end
          rde_pkg::CMD_DELETE,
          rde_pkg::CMD_TAKE: begin
            if (is_empty) begin
              if (cmd_i == rde_pkg::CMD_DELETE) begin
                err_d    = 1'b1;
                status_d = rde_pkg::ST_ERR;
              end else begin
                status_d = rde_pkg::ST_EMPTY;
              end
            end else begin
              count_d = count_q - CntW'(1);
              if (rev_q) begin
                mem_raddr = tail_slot - PtrW'(1);
              end else begin
                mem_raddr = head_q;
                head_d    = head_q + PtrW'(1);
              end
              if (cmd_i == rde_pkg::CMD_TAKE) begin
                mem_re     = 1'b1;
                word_sel_d = 1'b1;
                last_d     = (count_q == CntW'(1));
              end
            end
          end
          default: begin
            status_d = rde_pkg::ST_OK;
          end
        endcase
      end
    end
  end

  // Hold control state and the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= rde_pkg::ST_OK;
      last_q      <= 1'b0;
      word_sel_q  <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      last_q      <= last_d;
      word_sel_q  <= word_sel_d;
    end
  end

  // Write and read the element store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= data_word_i;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign last_one_o  = last_q;
  assign out_word_o  = word_sel_q ? rd_data_q : '0;

  // Checks
  `RDE_ASSERT(a_count_bound, count_q <= CntW'(rde_pkg::DEPTH),
    "element count exceeds store depth")
  `RDE_ASSERT(a_last_has_word, !last_q || (word_sel_q && status_q == rde_pkg::ST_OK),
    "last flag set without a returned word")
  `RDE_ASSERT_NEXT(a_take_result,
    in_fire && !err_q && !is_empty && cmd_i == rde_pkg::CMD_TAKE,
    out_valid_q && word_sel_q && status_q == rde_pkg::ST_OK,
    "take-out on a live deque did not return a word")
  `RDE_ASSERT_NEXT(a_reverse_toggle,
    in_fire && !err_q && cmd_i == rde_pkg::CMD_REVERSE,
    rev_q != $past(rev_q),
    "reverse command did not flip the direction")

endmodule

`default_nettype wire
